### design/eabv_pkg.sv
// shared types, constants and helpers for the euler angle to basis vector unit
// no dependencies
package eabv_pkg;

   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 14;
   localparam int CORDIC_STEPS       = 30;
   localparam int VAL_W              = 32;
   localparam int ITER_W             = 33;
   localparam logic signed [ITER_W-1:0] CORDIC_START = 33'sd652032874;
   localparam logic signed [VAL_W-1:0]  ONE_Q30      = 32'sd1073741824;

   localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef struct packed {
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] roll_angle;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_data_type;

   // q30 product with round half up
   function automatic logic signed [VAL_W-1:0] mul_q30(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
      logic signed [63:0] p;
      logic signed [63:0] r;
      p = 64'(a) * 64'(b);
      r = (p + 64'sd536870912) >>> 30;
      return r[VAL_W-1:0];
   endfunction

endpackage

### design/eabv_cordic.sv
// one cordic lane: angle fold, 30 rotation stages, flip and clamp stage
// depends on eabv_pkg
module eabv_cordic #(
   parameter int ANGLE_BITS = eabv_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [15:0]                       angle,
   output logic signed [eabv_pkg::VAL_W-1:0] sin_out,
   output logic signed [eabv_pkg::VAL_W-1:0] cos_out
);
   import eabv_pkg::*;

   logic [31:0]              ext;
   logic [31:0]              turn;
   logic signed [ITER_W-1:0] z0;
   logic signed [ITER_W-1:0] zf;
   logic                     flip0;

   logic signed [ITER_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [ITER_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [ITER_W-1:0] z_ff [CORDIC_STEPS];
   logic                     flip_ff [CORDIC_STEPS];
   logic signed [VAL_W-1:0]  sin_ff, cos_ff;
   logic signed [VAL_W-1:0]  sin_in, cos_in;

   assign ext  = {16'b0, angle};
   assign turn = ext << (32 - ANGLE_BITS);
   assign z0   = ITER_W'(signed'(turn));

   // fold to within a quarter turn, negate at the end
   always_comb begin
      zf    = z0;
      flip0 = 1'b0;
      if (z0 > ITER_W'(ONE_Q30)) begin
         zf    = z0 - 33'sd2147483648;
         flip0 = 1'b1;
      end else if (z0 < -ITER_W'(ONE_Q30)) begin
         zf    = z0 + 33'sd2147483648;
         flip0 = 1'b1;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [ITER_W-1:0] xi, yi, zi, xo, yo, zo, at;
      logic                     fi;
      if (i == 0) begin : g_first
         assign xi = CORDIC_START;
         assign yi = '0;
         assign zi = zf;
         assign fi = flip0;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
         assign fi = flip_ff[i-1];
      end
      assign at = ITER_W'(ATAN_TURN32[i]);
      always_comb begin
         if (!zi[ITER_W-1]) begin
            xo = xi - (yi >>> i);
            yo = yi + (xi >>> i);
            zo = zi - at;
         end else begin
            xo = xi + (yi >>> i);
            yo = yi - (xi >>> i);
            zo = zi + at;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= xo;
            y_ff[i]    <= yo;
            z_ff[i]    <= zo;
            flip_ff[i] <= fi;
         end
      end
   end

   always_comb begin
      logic signed [ITER_W-1:0] xs, ys;
      xs = flip_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1];
      ys = flip_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1];
      if (xs > ITER_W'(ONE_Q30))       cos_in = ONE_Q30;
      else if (xs < -ITER_W'(ONE_Q30)) cos_in = -ONE_Q30;
      else                             cos_in = xs[VAL_W-1:0];
      if (ys > ITER_W'(ONE_Q30))       sin_in = ONE_Q30;
      else if (ys < -ITER_W'(ONE_Q30)) sin_in = -ONE_Q30;
      else                             sin_in = ys[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

### design/eabv_combine.sv
// products, triple products and output rounding, three register stages
// depends on eabv_pkg
module eabv_combine #(
   parameter int FRAC_BITS = eabv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [eabv_pkg::VAL_W-1:0] sp,
   input  logic signed [eabv_pkg::VAL_W-1:0] cp,
   input  logic signed [eabv_pkg::VAL_W-1:0] sy,
   input  logic signed [eabv_pkg::VAL_W-1:0] cy,
   input  logic signed [eabv_pkg::VAL_W-1:0] sr,
   input  logic signed [eabv_pkg::VAL_W-1:0] cr,
   output eabv_pkg::rsp_data_type            data_out
);
   import eabv_pkg::*;

   localparam int SUM_W = 34;
   localparam int SHIFT = 30 - FRAC_BITS;
   localparam logic signed [SUM_W-1:0] RND =
      (SHIFT == 0) ? '0 : (SUM_W'(1) <<< ((SHIFT == 0) ? 0 : SHIFT - 1));
   localparam logic signed [SUM_W-1:0] LIM = SUM_W'(1) <<< FRAC_BITS;

   function automatic logic [15:0] emit(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + RND) >>> SHIFT;
      if (r > LIM)       r = LIM;
      else if (r < -LIM) r = -LIM;
      return r[15:0];
   endfunction

   // stage a: pairwise products
   logic signed [VAL_W-1:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, srcp_ff, crcp_ff;
   logic signed [VAL_W-1:0] crsy_ff, crcy_ff, srsy_ff, srcy_ff, cy_ff, sy_ff, spa_ff;
   // stage b: triple products
   logic signed [VAL_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [VAL_W-1:0] bcpcy_ff, bcpsy_ff, bsrcp_ff, bcrcp_ff, bsp_ff;
   logic signed [VAL_W-1:0] bcrsy_ff, bcrcy_ff, bsrsy_ff, bsrcy_ff;
   rsp_data_type            out_ff, out_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         srsp_ff <= mul_q30(sr, sp);
         crsp_ff <= mul_q30(cr, sp);
         cpcy_ff <= mul_q30(cp, cy);
         cpsy_ff <= mul_q30(cp, sy);
         srcp_ff <= mul_q30(sr, cp);
         crcp_ff <= mul_q30(cr, cp);
         crsy_ff <= mul_q30(cr, sy);
         crcy_ff <= mul_q30(cr, cy);
         srsy_ff <= mul_q30(sr, sy);
         srcy_ff <= mul_q30(sr, cy);
         cy_ff   <= cy;
         sy_ff   <= sy;
         spa_ff  <= sp;

         t1_ff    <= mul_q30(srsp_ff, cy_ff);
         t2_ff    <= mul_q30(srsp_ff, sy_ff);
         t3_ff    <= mul_q30(crsp_ff, cy_ff);
         t4_ff    <= mul_q30(crsp_ff, sy_ff);
         bcpcy_ff <= cpcy_ff;
         bcpsy_ff <= cpsy_ff;
         bsrcp_ff <= srcp_ff;
         bcrcp_ff <= crcp_ff;
         bsp_ff   <= spa_ff;
         bcrsy_ff <= crsy_ff;
         bcrcy_ff <= crcy_ff;
         bsrsy_ff <= srsy_ff;
         bsrcy_ff <= srcy_ff;

         out_ff <= out_in;
      end
   end

   always_comb begin
      out_in.fwd_x   = emit(SUM_W'(bcpcy_ff));
      out_in.fwd_y   = emit(SUM_W'(bcpsy_ff));
      out_in.fwd_z   = emit(-SUM_W'(bsp_ff));
      out_in.right_x = emit(SUM_W'(bcrsy_ff) - SUM_W'(t1_ff));
      out_in.right_y = emit(-SUM_W'(t2_ff) - SUM_W'(bcrcy_ff));
      out_in.right_z = emit(-SUM_W'(bsrcp_ff));
      out_in.up_x    = emit(SUM_W'(t3_ff) + SUM_W'(bsrsy_ff));
      out_in.up_y    = emit(SUM_W'(t4_ff) - SUM_W'(bsrcy_ff));
      out_in.up_z    = emit(SUM_W'(bcrcp_ff));
   end

   assign data_out = out_ff;

endmodule

### design/euler_angles_to_basis_vectors_unit.sv
// an accepted item passes 30 cordic stages, one clamp stage and three product and
// rounding stages on its way to its result
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// reset clears only the valid bits of the pipeline
// top level, depends on eabv_pkg, eabv_cordic and eabv_combine
module euler_angles_to_basis_vectors_unit #(
   parameter int ANGLE_BITS = eabv_pkg::ANGLE_BITS_DEFAULT,
   parameter int FRAC_BITS  = eabv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  eabv_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output eabv_pkg::rsp_data_type rsp_data
);
   import eabv_pkg::*;

   localparam int DEPTH = CORDIC_STEPS + 4;

   logic                    advance;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic signed [VAL_W-1:0] sp, cp, sy, cy, sr, cr;

   assign advance   = !(valid_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[DEPTH-1];
   assign valid_in  = {valid_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   eabv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .advance(advance), .angle(req_data.pitch_angle),
      .sin_out(sp), .cos_out(cp));
   eabv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .advance(advance), .angle(req_data.yaw_angle),
      .sin_out(sy), .cos_out(cy));
   eabv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .advance(advance), .angle(req_data.roll_angle),
      .sin_out(sr), .cos_out(cr));

   eabv_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
      .clock(clock), .advance(advance),
      .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .data_out(rsp_data));

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");
   a_stall: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall not tied to output stall");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

### dv/tb_euler_angles_to_basis_vectors_unit.sv
// testbench for euler_angles_to_basis_vectors_unit: directed and random angle sets,
// predicted basis vectors checked field by field against each result item
// depends on eabv_pkg and the rtl of the unit
module tb_euler_angles_to_basis_vectors_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import eabv_pkg::*;

   localparam int LATENCY = 34;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;

   rsp_data_type expected_vectors[$];
   int  error_count;
   int  items_sent;
   int  results_seen;
   bit  quiet_mode;
   bit  hold_request;
   bit  holding;
   int  hold_cycles;

   euler_angles_to_basis_vectors_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sine and cosine in q30 of a 16-bit binary angle
   function automatic void angle_sin_cos(input logic [15:0] angle, output longint s,
                                         output longint c);
      longint z, x, y, nx;
      bit     flip;
      logic [31:0] t;
      t = {angle, 16'h0000};
      z = longint'($signed(t));
      flip = 1'b0;
      x = longint'(CORDIC_START);
      y = 0;
      if (z > 64'sd1073741824) begin
         z = z - 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z = z + 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ATAN_TURN32[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ATAN_TURN32[i]);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = (x > 64'sd1073741824) ? 64'sd1073741824 : (x < -64'sd1073741824) ? -64'sd1073741824 : x;
      s = (y > 64'sd1073741824) ? 64'sd1073741824 : (y < -64'sd1073741824) ? -64'sd1073741824 : y;
   endfunction

   function automatic longint times_q30(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   // q30 to q1.14 with round half up and saturation
   function automatic logic [15:0] to_q14(input longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic rsp_data_type basis_vectors(input req_data_type a);
      longint sp, cp, sy, cy, sr, cr, srsp, crsp;
      rsp_data_type v;
      angle_sin_cos(a.pitch_angle, sp, cp);
      angle_sin_cos(a.yaw_angle, sy, cy);
      angle_sin_cos(a.roll_angle, sr, cr);
      srsp = times_q30(sr, sp);
      crsp = times_q30(cr, sp);
      v.fwd_x   = to_q14(times_q30(cp, cy));
      v.fwd_y   = to_q14(times_q30(cp, sy));
      v.fwd_z   = to_q14(-sp);
      v.right_x = to_q14(-times_q30(srsp, cy) + times_q30(cr, sy));
      v.right_y = to_q14(-times_q30(srsp, sy) - times_q30(cr, cy));
      v.right_z = to_q14(-times_q30(sr, cp));
      v.up_x    = to_q14(times_q30(crsp, cy) + times_q30(sr, sy));
      v.up_y    = to_q14(times_q30(crsp, sy) - times_q30(sr, cy));
      v.up_z    = to_q14(times_q30(cr, cp));
      return v;
   endfunction

   // offers one item from a falling edge until accepted, with an occasional gap first
   task automatic send_angles(input logic [15:0] p, input logic [15:0] y, input logic [15:0] r);
      req_data_type a;
      a.pitch_angle = p;
      a.yaw_angle   = y;
      a.roll_angle  = r;
      @(negedge clock);
      while (!quiet_mode && $urandom_range(99) < 9) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = a;
      do @(posedge clock); while (req_stall);
      expected_vectors.push_back(basis_vectors(a));
      items_sent++;
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      go_idle();
      while (expected_vectors.size() != 0) @(posedge clock);
   endtask

   // receiver stall: random, quiet, or one long hold counted here
   always @(negedge clock) begin
      if (hold_request && !holding) begin
         holding = 1'b1;
         hold_cycles = 0;
      end
      if (holding) begin
         rsp_stall <= 1'b1;
         hold_cycles++;
         if (hold_cycles >= 120) begin
            holding = 1'b0;
            hold_request = 1'b0;
         end
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(99) < 9);
      end
   end

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_vectors.size() == 0) begin
            $display("%0t: result item with nothing expected, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_vectors.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (want[143-16*k -: 16] !== rsp_data[143-16*k -: 16]) begin
                  $display("%0t: field %0d mismatch, expected %0d actual %0d", $time, k,
                           $signed(want[143-16*k -: 16]), $signed(rsp_data[143-16*k -: 16]));
                  error_count++;
               end
            end
         end
      end
   end

   task automatic test_angle_extremes();
      logic [15:0] corner[12] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                                   16'h2000, 16'h4001, 16'hBFFF, 16'h3FFF, 16'hC001,
                                   16'hFFFF, 16'h0001};
      foreach (corner[i]) send_angles(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12]);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_angles(16'h4000, 16'h0000, 16'h0000);
      send_angles(16'hC000, 16'h4000, 16'hC000);
      send_angles(16'hAAAA, 16'h5555, 16'hFFFF);
      wait_drained();
   endtask

   task automatic test_random_angles(input int count);
      for (int n = 0; n < count; n++) begin
         quiet_mode = (n >= count / 2) && (n < count / 2 + 150);
         send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
      end
      quiet_mode = 1'b0;
   endtask

   // receiver holds off while items keep coming so the pipeline fills
   task automatic test_output_hold();
      hold_request = 1'b1;
      for (int n = 0; n < 100; n++)
         send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
      wait_drained();
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      error_count = 0;
      items_sent = 0;
      results_seen = 0;
      quiet_mode = 1'b0;
      hold_request = 1'b0;
      holding = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_angle_extremes();
      test_random_angles(500);
      test_output_hold();
      test_random_angles(600);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d angle sets, %0d result items, with corner angles, quarter-turn",
               items_sent, results_seen);
      $display("wraps, random idling and a long output hold");
      if (error_count == 0 && expected_vectors.size() == 0)
         $display("euler_angles_to_basis_vectors_unit verification clean");
      else
         $display("euler_angles_to_basis_vectors_unit verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("euler_angles_to_basis_vectors_unit verification failed");
      $finish;
   end
endmodule

### filelist.f
design/eabv_pkg.sv
design/eabv_cordic.sv
design/eabv_combine.sv
design/euler_angles_to_basis_vectors_unit.sv
dv/tb_euler_angles_to_basis_vectors_unit.sv
